// ===== rtl/icdf_pkg.sv =====
// Package: shared types and constants for the inverse CDF table builder.
package icdf_pkg;

   localparam int IDX_W = 9;   // entry index field width
   localparam int POS_W = 32;  // Q16.16 position width
   localparam int MAG_W = 33;  // |range_max - range_min|
   localparam int CSR_W = 32;  // widest register
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT = 2'd2;

   localparam logic [1:0] STAT_VALID  = 2'd0;
   localparam logic [1:0] STAT_LOADED = 2'd1;
   localparam logic [1:0] STAT_ZERO   = 2'd2;
   localparam logic [1:0] STAT_ERROR  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_S0,
      ST_RD_T,
      ST_MUL_A,
      ST_MUL_B,
      ST_ADD_N,
      ST_SCAN,
      ST_G_MUL,
      ST_X_MUL,
      ST_DEN_MUL,
      ST_DEN_SET,
      ST_START,
      ST_WAIT,
      ST_EMIT
   } icdf_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_DONE
   } md_state_type;

endpackage

// ===== rtl/icdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module icdf_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 257
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/icdf_muldiv.sv =====
// Bit-serial multiply (mag * x) followed by restoring divide by den.
module icdf_muldiv #(
   parameter int X_W = 43
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [icdf_pkg::MAG_W-1:0] mag,
   input  logic [X_W-1:0]           x,
   input  logic [X_W-1:0]           den,
   output logic                     done,
   output logic [icdf_pkg::MAG_W+X_W-1:0] quo
);
   import icdf_pkg::*;

   localparam int PW  = MAG_W + X_W;
   localparam int CW  = $clog2(PW + 1);

   md_state_type     state_ff, state_in;
   logic [PW-1:0]    acc_ff;
   logic [X_W-1:0]   rem_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [X_W-1:0]   x_ff;
   logic [X_W-1:0]   den_ff;
   logic [CW-1:0]    cnt_ff;
   logic [X_W:0]     rem_sh;
   logic             fits;
   logic             last;

   assign rem_sh = {rem_ff, acc_ff[PW-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      last = 1'b0;
      unique case (state_ff)
         MD_MUL:  last = (cnt_ff == CW'(MAG_W - 1));
         MD_DIV:  last = (cnt_ff == CW'(PW - 1));
         default: last = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE: if (start) state_in = MD_MUL;
         MD_MUL:  if (last) state_in = MD_DIV;
         MD_DIV:  if (last) state_in = MD_DONE;
         MD_DONE: state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == MD_DONE);
      quo  = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == MD_IDLE || last) begin
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         MD_IDLE: begin
            acc_ff <= '0;
            rem_ff <= '0;
            mag_ff <= mag;
            x_ff   <= x;
            den_ff <= den;
         end
         MD_MUL: begin
            acc_ff <= {acc_ff[PW-2:0], 1'b0} + (mag_ff[MAG_W-1] ? PW'(x_ff) : '0);
            mag_ff <= {mag_ff[MAG_W-2:0], 1'b0};
         end
         MD_DIV: begin
            if (fits) begin
               rem_ff <= X_W'(rem_sh - {1'b0, den_ff});
            end else begin
               rem_ff <= rem_sh[X_W-1:0];
            end
            acc_ff <= {acc_ff[PW-2:0], fits};
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/inverse_cdf_table_builder.sv =====
// Top level: inverse CDF table builder with sequencer and shared multiplier.
//
//   channel | direction | handshake             | word
//   req_    | in        | req_valid / req_ready | op, density, entry_index
//   rsp_    | out       | rsp_valid / rsp_ready | position, status
//   csr_    | in        | csr_we                | index, wdata
//
// Load words are accepted back to back; a load's last sample and an error or
// end-entry read pass their word from the pending register to the output register
// in ST_EMIT. An inner read's word waits on the bin scan, which runs up to j, the
// bin found, and on the serial multiply/divide. A flat bin skips ST_DEN_MUL and
// ST_DEN_SET. req_ready is low while a read runs. Reset is synchronous; the sum
// RAM is not cleared. A stalled result holds in the output register; loads go on
// meanwhile and the next result waits until it frees.
module inverse_cdf_table_builder #(
   parameter int MAX_BINS    = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [SAMPLE_BITS-1:0]             req_density,
   input  logic [icdf_pkg::IDX_W-1:0]         req_entry_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [icdf_pkg::POS_W-1:0]         rsp_position,
   output logic [1:0]                         rsp_status,
   input  logic                               csr_we,
   input  logic [icdf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [icdf_pkg::CSR_W-1:0]         csr_wdata
);
   import icdf_pkg::*;

   localparam int CNT_W = $clog2(MAX_BINS + 1);
   localparam int SUM_W = SAMPLE_BITS + CNT_W;  // running sum
   localparam int NW    = SUM_W + CNT_W;        // L * sum
   localparam int XW    = NW + CNT_W;           // L * L * sum
   localparam int PW    = MAG_W + XW;
   localparam int BINS_RST = (MAX_BINS < 256) ? MAX_BINS : 256;

   // configuration
   logic [POS_W-1:0] range_min_ff, range_max_ff;
   logic [CNT_W-1:0] bin_count_ff;
   logic [8:0]       csr_bins;

   // load state
   logic [CNT_W-1:0] loaded_count_ff;
   logic             table_ready_ff;
   logic [SUM_W-1:0] last_sum_ff;
   logic [SUM_W-1:0] new_sum;

   // sequencer
   icdf_state_type   state_ff, state_in;
   logic             accept;
   logic             rsp_load;

   // read datapath
   logic [CNT_W-1:0] i_ff;
   logic [SUM_W-1:0] s0_ff, t_ff, prev_ff, sum2_ff, sj_ff, sjm_ff;
   logic [NW-1:0]    ls0_ff, n_ff, prevp_ff, f_ff, g_ff;
   logic [CNT_W-1:0] j_ff, k2_ff;
   logic [CNT_W:0]   kcnt_ff;
   logic             v1_ff, v2_ff;
   logic [CNT_W-1:0] k1_ff;
   logic [XW-1:0]    x_ff, den_ff;
   logic [XW-1:0]    p_ff;
   logic             hit;

   // shared multiplier operands
   logic [CNT_W-1:0] mul_a;
   logic [NW-1:0]    mul_b;

   // RAM
   logic             ram_we;
   logic [CNT_W-1:0] ram_raddr;
   logic [SUM_W-1:0] ram_rdata;
   logic             issue;

   // divider
   logic             md_start, md_done;
   logic [PW-1:0]    md_quo;

   // pending and output words
   logic [POS_W-1:0] pend_pos_ff, rsp_pos_ff;
   logic [1:0]       pend_stat_ff, rsp_stat_ff;
   logic             rsp_valid_ff;

   // position arithmetic
   logic signed [MAG_W-1:0] diff;
   logic [MAG_W-1:0]        mag;
   logic [MAG_W-1:0]        off;
   logic                    bad_read;

   assign accept  = req_valid && req_ready;
   assign new_sum = (loaded_count_ff == '0) ? SUM_W'(req_density)
                                            : last_sum_ff + SUM_W'(req_density);
   assign diff = $signed({range_max_ff[POS_W-1], range_max_ff})
               - $signed({range_min_ff[POS_W-1], range_min_ff});
   assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
   assign off  = (md_quo > PW'(mag)) ? mag : md_quo[MAG_W-1:0];
   assign bad_read = !table_ready_ff
                  || (32'(req_entry_index) > 32'(bin_count_ff));
   assign hit = v2_ff && ((p_ff >= XW'(n_ff)) || (k2_ff == bin_count_ff));
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign csr_bins = csr_wdata[8:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_op) begin
                  if (loaded_count_ff == bin_count_ff) state_in = ST_EMIT;
               end else if (bad_read || req_entry_index == '0
                            || 32'(req_entry_index) == 32'(bin_count_ff)) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_RD_S0;
               end
            end
         end
         ST_RD_S0:   state_in = ST_RD_T;
         ST_RD_T:    state_in = ST_MUL_A;
         ST_MUL_A:   state_in = ST_MUL_B;
         ST_MUL_B:   state_in = ST_ADD_N;
         ST_ADD_N:   state_in = ST_SCAN;
         ST_SCAN:    if (hit) state_in = ST_G_MUL;
         ST_G_MUL:   state_in = ST_X_MUL;
         ST_X_MUL:   state_in = (p_ff == '0) ? ST_START : ST_DEN_MUL;
         ST_DEN_MUL: state_in = ST_DEN_SET;
         ST_DEN_SET: state_in = ST_START;
         ST_START:   state_in = ST_WAIT;
         ST_WAIT:    if (md_done) state_in = ST_EMIT;
         ST_EMIT:    if (rsp_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      ram_we    = accept && !req_op;
      ram_raddr = '0;
      issue     = 1'b0;
      md_start  = (state_ff == ST_START);
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_RD_T:  ram_raddr = bin_count_ff;
         ST_MUL_A: begin
            mul_a = bin_count_ff;
            mul_b = NW'(s0_ff);
         end
         ST_MUL_B: begin
            mul_a = i_ff;
            mul_b = NW'(t_ff - s0_ff);
         end
         ST_SCAN: begin
            issue     = !hit && (kcnt_ff <= (CNT_W+1)'(bin_count_ff));
            ram_raddr = kcnt_ff[CNT_W-1:0];
            mul_a     = bin_count_ff;
            mul_b     = NW'(ram_rdata);
         end
         ST_G_MUL: begin
            mul_a = bin_count_ff;
            mul_b = NW'(sj_ff - sjm_ff);
         end
         ST_X_MUL: begin
            mul_a = j_ff - CNT_W'(1);
            mul_b = p_ff[NW-1:0];
         end
         ST_DEN_MUL: begin
            mul_a = bin_count_ff;
            mul_b = g_ff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         range_min_ff    <= '0;
         range_max_ff    <= POS_W'(65536);
         bin_count_ff    <= CNT_W'(BINS_RST);
         loaded_count_ff <= '0;
         table_ready_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= (state_ff == ST_SCAN) && v1_ff && !hit;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_RANGE_MIN: range_min_ff <= csr_wdata;
               CSR_RANGE_MAX: range_max_ff <= csr_wdata;
               CSR_BIN_COUNT: begin
                  if (csr_bins < 9'd2) begin
                     bin_count_ff <= CNT_W'(2);
                  end else if (32'(csr_bins) > MAX_BINS) begin
                     bin_count_ff <= CNT_W'(MAX_BINS);
                  end else begin
                     bin_count_ff <= CNT_W'(csr_bins);
                  end
                  loaded_count_ff <= '0;
                  table_ready_ff  <= 1'b0;
               end
               default: begin
               end
            endcase
         end else if (accept && !req_op) begin
            if (loaded_count_ff == bin_count_ff) begin
               loaded_count_ff <= '0;
               table_ready_ff  <= (new_sum != '0);
            end else begin
               loaded_count_ff <= loaded_count_ff + CNT_W'(1);
               if (loaded_count_ff == '0) table_ready_ff <= 1'b0;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      p_ff    <= XW'(mul_a) * XW'(mul_b);
      k1_ff   <= kcnt_ff[CNT_W-1:0];
      k2_ff   <= k1_ff;
      sum2_ff <= ram_rdata;
      if (issue) kcnt_ff <= kcnt_ff + (CNT_W+1)'(1);
      if (rsp_load) begin
         rsp_pos_ff  <= pend_pos_ff;
         rsp_stat_ff <= pend_stat_ff;
      end
      unique case (state_ff)
         ST_IDLE: begin
            i_ff <= CNT_W'(req_entry_index);
            if (accept && !req_op) begin
               last_sum_ff  <= new_sum;
               pend_pos_ff  <= '0;
               pend_stat_ff <= (new_sum == '0) ? STAT_ZERO : STAT_LOADED;
            end else if (accept) begin
               pend_stat_ff <= bad_read ? STAT_ERROR : STAT_VALID;
               if (bad_read) begin
                  pend_pos_ff <= '0;
               end else if (req_entry_index == '0) begin
                  pend_pos_ff <= range_min_ff;
               end else begin
                  pend_pos_ff <= range_max_ff;
               end
            end
         end
         ST_RD_T:  s0_ff <= ram_rdata;
         ST_MUL_A: t_ff  <= ram_rdata;
         ST_MUL_B: ls0_ff <= p_ff[NW-1:0];
         ST_ADD_N: begin
            n_ff     <= ls0_ff + p_ff[NW-1:0];
            prev_ff  <= s0_ff;
            prevp_ff <= ls0_ff;
            kcnt_ff  <= (CNT_W+1)'(1);
         end
         ST_SCAN: begin
            if (hit) begin
               j_ff   <= k2_ff;
               sj_ff  <= sum2_ff;
               sjm_ff <= prev_ff;
               f_ff   <= n_ff - prevp_ff;
            end else if (v2_ff) begin
               prev_ff  <= sum2_ff;
               prevp_ff <= p_ff[NW-1:0];
            end
         end
         ST_X_MUL: begin
            g_ff   <= p_ff[NW-1:0];
            // flat bin: in-bin offset is zero
            x_ff   <= XW'(j_ff - CNT_W'(1));
            den_ff <= XW'(bin_count_ff);
         end
         ST_DEN_MUL: x_ff   <= p_ff + XW'((f_ff > g_ff) ? g_ff : f_ff);
         ST_DEN_SET: den_ff <= p_ff;
         ST_WAIT: begin
            pend_stat_ff <= STAT_VALID;
            pend_pos_ff  <= diff[MAG_W-1] ? range_min_ff - off[POS_W-1:0]
                                          : range_min_ff + off[POS_W-1:0];
         end
         default: begin
         end
      endcase
   end

   icdf_ram #(
      .WIDTH(SUM_W),
      .DEPTH(MAX_BINS + 1)
   ) u_sums (
      .clock(clock),
      .we(ram_we),
      .waddr(loaded_count_ff),
      .wdata(new_sum),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   icdf_muldiv #(
      .X_W(XW)
   ) u_muldiv (
      .clock(clock),
      .reset(reset),
      .start(md_start),
      .mag(mag),
      .x(x_ff),
      .den(den_ff),
      .done(md_done),
      .quo(md_quo)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_status   = rsp_stat_ff;

endmodule

// ===== rtl/icdf_checker.sv =====
// Port checker for the inverse CDF table builder, bound to the top level.
module icdf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_op,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [icdf_pkg::POS_W-1:0]     rsp_position,
   input logic [1:0]                     rsp_status
);
   import icdf_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
                                  && $stable(rsp_status))
      else $error("rsp word changed while stalled");

   // status-only words carry a zero position
   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_ERROR || rsp_status == STAT_LOADED
                    || rsp_status == STAT_ZERO) |-> rsp_position == '0)
      else $error("nonzero position with status-only word");

   // a read keeps the input side busy
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op |=> !req_ready)
      else $error("req_ready high right after a read");

endmodule

bind inverse_cdf_table_builder icdf_checker u_icdf_checker (.*);

// ===== dv/inverse_cdf_table_builder_tb.sv =====
// Testbench for the inverse CDF table builder: directed table, then random load/read phases.
`timescale 1ns / 100ps

module inverse_cdf_table_builder_tb;
   import icdf_pkg::*;

   // ------------------------------------------------------------------
   // DUT ports
   // ------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_op = 1'b0;
   logic [15:0]          req_density = '0;
   logic [IDX_W-1:0]     req_entry_index = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [POS_W-1:0]     rsp_position;
   logic [1:0]           rsp_status;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   inverse_cdf_table_builder dut (.*);

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the block: registers, sum store, load state
   // ------------------------------------------------------------------
   logic [31:0] sh_range_min;
   logic [31:0] sh_range_max;
   int unsigned sh_bins;
   longint unsigned sh_sums [0:256];
   int unsigned sh_loaded;
   bit          sh_ready;

   typedef struct {
      logic [POS_W-1:0] pos;
      logic [1:0]       st;
   } icdf_result_type;

   icdf_result_type pending_results[$];

   int  err_count = 0;
   int  n_words = 0;
   bit  quiet = 1'b0;      // no idling on either side
   bit  quiet_done = 1'b0;
   bit  hold_rsp = 1'b0;   // request a long receiver hold-off
   bit  held = 1'b0;

   // register write as the block sees it
   function automatic void shadow_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      int unsigned v;
      if (idx == CSR_RANGE_MIN) begin
         sh_range_min = val;
      end else if (idx == CSR_RANGE_MAX) begin
         sh_range_max = val;
      end else if (idx == CSR_BIN_COUNT) begin
         v = val[8:0];
         if (v < 2) v = 2;
         if (v > 256) v = 256;
         sh_bins = v;
         sh_loaded = 0;
         sh_ready = 1'b0;
      end
   endfunction

   // one word in; returns 1 when it yields a result
   function automatic bit icdf_predict(bit op, logic [15:0] dens, logic [8:0] idx,
                                       output icdf_result_type res);
      longint unsigned L, T, S0, N, f, g, x, den, j, off, mag;
      longint signed   mn, mx, diff;
      logic [127:0]    prod;
      L = sh_bins;
      res.pos = '0;
      if (op == 1'b0) begin
         if (sh_loaded == 0) begin
            sh_ready = 1'b0;
            sh_sums[0] = dens;
         end else begin
            sh_sums[sh_loaded] = sh_sums[sh_loaded-1] + dens;
         end
         sh_loaded++;
         if (sh_loaded < L + 1) return 1'b0;
         sh_loaded = 0;
         if (sh_sums[L] == 0) begin
            res.st = STAT_ZERO;
         end else begin
            sh_ready = 1'b1;
            res.st = STAT_LOADED;
         end
         return 1'b1;
      end
      mn = $signed(sh_range_min);
      mx = $signed(sh_range_max);
      diff = mx - mn;
      mag = (diff < 0) ? -diff : diff;
      if (!sh_ready || idx > L) begin
         res.st = STAT_ERROR;
         return 1'b1;
      end
      res.st = STAT_VALID;
      if (idx == 0) begin
         res.pos = sh_range_min;
         return 1'b1;
      end
      if (idx == L) begin
         res.pos = sh_range_max;
         return 1'b1;
      end
      T  = sh_sums[L];
      S0 = sh_sums[0];
      N  = idx * (T - S0) + L * S0;
      j  = L;
      for (int k = 1; k <= L; k++) begin
         if (sh_sums[k] * L >= N) begin
            j = k;
            break;
         end
      end
      f = (N > L * sh_sums[j-1]) ? N - L * sh_sums[j-1] : 0;
      g = L * (sh_sums[j] - sh_sums[j-1]);
      if (g == 0) begin
         // flat bin: no in-bin offset
         x = j - 1;
         den = L;
      end else begin
         if (f > g) f = g;
         x = (j - 1) * g + f;
         den = L * g;
      end
      prod = 128'(mag) * 128'(x);
      off = 64'(prod / 128'(den));
      if (off > mag) off = mag;
      res.pos = (diff < 0) ? 32'(mn - longint'(off)) : 32'(mn + longint'(off));
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Driving helpers
   // ------------------------------------------------------------------
   // offer one word, hold it until accepted, then log the expected result
   task automatic send_word(bit op, logic [15:0] dens, logic [8:0] idx,
                            bit typed = 1'b0, logic [31:0] tpos = '0, logic [1:0] tst = '0);
      icdf_result_type res;
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_density     <= dens;
      req_entry_index <= idx;
      do @(posedge clock); while (!req_ready);
      n_words++;
      if (icdf_predict(op, dens, idx, res)) begin
         if (typed) begin
            res.pos = tpos;
            res.st  = tst;
         end
         pending_results.push_back(res);
      end
   endtask

   // drain: all results back, then allow a full read time for a load in flight
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      shadow_csr(idx, val);
   endtask

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   typedef struct {
      bit               is_csr;
      bit               op;
      logic [31:0]      val;     // density, entry index or register data
      logic [1:0]       reg_i;
      bit               typed;
      logic [31:0]      tpos;
      logic [1:0]       tst;
   } step_type;

   step_type steps [] = '{
      '{0, 1, 0,            0, 1, 0,            STAT_ERROR},  // read before any load
      '{1, 0, 2,            CSR_BIN_COUNT, 0, 0, 0},
      '{0, 0, 0,            0, 0, 0,            0},
      '{0, 0, 0,            0, 0, 0,            0},
      '{0, 0, 0,            0, 1, 0,            STAT_ZERO},   // all-zero load
      '{0, 1, 1,            0, 1, 0,            STAT_ERROR},
      '{0, 0, 16'hffff,     0, 0, 0,            0},
      '{0, 0, 0,            0, 0, 0,            0},
      '{0, 0, 16'hffff,     0, 1, 0,            STAT_LOADED},
      '{0, 1, 0,            0, 1, 0,            STAT_VALID},  // entry 0 = range_min
      '{0, 1, 2,            0, 1, 32'h10000,    STAT_VALID},  // last entry = range_max
      '{0, 1, 1,            0, 0, 0,            0},
      '{0, 1, 3,            0, 1, 0,            STAT_ERROR},  // beyond bin_count
      '{0, 1, 511,          0, 1, 0,            STAT_ERROR},
      '{1, 0, 32'h80000000, CSR_RANGE_MIN, 0, 0, 0},
      '{1, 0, 32'h7fffffff, CSR_RANGE_MAX, 0, 0, 0},
      '{0, 1, 0,            0, 1, 32'h80000000, STAT_VALID},
      '{0, 1, 2,            0, 1, 32'h7fffffff, STAT_VALID},
      '{0, 1, 1,            0, 0, 0,            0},
      '{1, 0, 32'h7fffffff, CSR_RANGE_MIN, 0, 0, 0},          // reversed range
      '{1, 0, 32'h80000000, CSR_RANGE_MAX, 0, 0, 0},
      '{0, 1, 1,            0, 0, 0,            0},
      '{0, 0, 7,            0, 0, 0,            0},          // new load drops ready
      '{0, 1, 1,            0, 1, 0,            STAT_ERROR},
      '{0, 0, 0,            0, 0, 0,            0},
      '{0, 0, 0,            0, 1, 0,            STAT_LOADED},
      '{0, 1, 1,            0, 0, 0,            0},          // flat bin
      '{1, 0, 32'hffffffff, 3,             0, 0, 0},          // unused index
      '{1, 0, 0,            CSR_BIN_COUNT, 0, 0, 0},          // saturates to 2
      '{0, 1, 1,            0, 1, 0,            STAT_ERROR}
   };

   // ------------------------------------------------------------------
   // Random phase: configure, load, read
   // ------------------------------------------------------------------
   task automatic random_phase();
      int unsigned nreads, mode, L, partial;
      logic [15:0] d;
      logic [31:0] v;
      wait_idle();
      mode = $urandom_range(99);
      if (mode >= 15) begin
         // new geometry; mostly small tables, a few full size or out of range
         if ($urandom_range(9) == 0) v = 256;
         else if ($urandom_range(9) == 0) v = $urandom_range(511);
         else v = $urandom_range(2, 16);
         write_csr(CSR_BIN_COUNT, v);
      end
      case ($urandom_range(5))
         0: v = 32'h80000000;
         1: v = 32'h7fffffff;
         default: v = $urandom;
      endcase
      write_csr(CSR_RANGE_MIN, $urandom_range(3) == 0 ? $urandom : {16'h0, 16'($urandom)});
      write_csr(CSR_RANGE_MAX, v);
      L = sh_bins;
      if (mode >= 15) begin
         if ($urandom_range(9) == 0) begin
            // noise: read early, then a broken load aborted by the next phase
            send_word(1'b1, 16'($urandom), 9'($urandom));
            partial = $urandom_range(1, L);
            for (int k = 0; k < partial; k++) send_word(1'b0, 16'($urandom), 9'($urandom));
            send_word(1'b1, 16'($urandom), 9'($urandom_range(L)));
            return;
         end
         mode = $urandom_range(19);
         for (int k = 0; k <= L; k++) begin
            case (mode)
               0:       d = 0;
               1, 2, 3: d = ($urandom_range(2) == 0) ? 16'($urandom) : 16'h0;
               4:       d = 16'($urandom_range(3));
               default: d = 16'($urandom);
            endcase
            send_word(1'b0, d, 9'($urandom));
         end
      end
      nreads = (L == 256) ? 4 : $urandom_range(5, 20);
      if (!held && n_words > 1000 && L < 256) begin
         held = 1'b1;
         hold_rsp = 1'b1;
         nreads = 20;
      end
      for (int k = 0; k < nreads; k++) begin
         send_word(1'b1, 16'($urandom),
                   ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(L)));
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: random back-pressure, one long hold-off
   // ------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (2500) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 9);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      icdf_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word: position %h status %0d", rsp_position, rsp_status);
            err_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_position !== exp_r.pos) begin
               $error("position: expected %h actual %h", exp_r.pos, rsp_position);
               err_count++;
            end
            if (rsp_status !== exp_r.st) begin
               $error("status: expected %0d actual %0d", exp_r.st, rsp_status);
               err_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      shadow_csr(CSR_RANGE_MIN, 32'h0);
      shadow_csr(CSR_RANGE_MAX, 32'h10000);
      shadow_csr(CSR_BIN_COUNT, 32'd256);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (steps[s]) begin
         if (steps[s].is_csr) begin
            wait_idle();
            write_csr(steps[s].reg_i, steps[s].val);
         end else begin
            send_word(steps[s].op, steps[s].val[15:0], steps[s].val[8:0],
                      steps[s].typed, steps[s].tpos, steps[s].tst);
         end
      end

      while (n_words < 1800) begin
         // at least one whole phase without idling once past 600 words
         quiet = (n_words > 600) && (n_words < 850 || !quiet_done);
         if (quiet) quiet_done = 1'b1;
         random_phase();
      end
      quiet = 1'b0;

      wait_idle();
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hard stop
   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
